>>> sv/hfs_pkg.sv
// Shared types and constants for the heap fit search block.
// Used by hfs_map_ram, hfs_ctrl and heap_fit_search_top; depends on nothing.

package hfs_pkg;

  // Default number of map units
  localparam int unsigned MAP_DEPTH_DEF = 1024;

  // Widths of positions and run lengths, chunk indexes and the register index port
  localparam int unsigned POS_W   = 11;
  localparam int unsigned CIDX_W  = 10;
  localparam int unsigned CFG_A_W = 1;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_STRATEGY = 1'b0;
  localparam logic [CFG_A_W-1:0] CFG_AREA     = 1'b1;

  // Reset value of the use area size
  localparam logic [POS_W-1:0] AREA_RST = 11'd1024;

  // Operation codes; code 3 has no meaning and is dropped
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SEARCH = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // Search strategies
  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_NEXT  = 2'd1,
    FIT_BEST  = 2'd2,
    FIT_WORST = 2'd3
  } fit_e;

  // Configuration seen by the controller
  typedef struct packed {
    fit_e             strategy;
    logic [POS_W-1:0] area;
  } cfg_t;

  // Map write control
  typedef struct packed {
    logic we;
    logic wbit;
  } map_ctl_t;

  // One result transaction
  typedef struct packed {
    logic              found;
    logic [CIDX_W-1:0] chunk_index;
    logic [POS_W-1:0]  chunk_size;
  } res_t;

endpackage

>>> sv/heap_fit_search_top.sv
// Heap fit search top level: configuration registers, output register,
// map memory and sequencer. Depends on hfs_pkg, hfs_map_ram and hfs_ctrl.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one operation per
//    transaction: write a map mark, search for a free run, or query the
//    size of the free run around an index. Writes and code 3 give no result.
//  - Output channel (out_valid_o/out_ready_i) returns found, chunk_index and
//    chunk_size for each search or query, in order.
//  - Registers are written through cfg_we_i/cfg_index_i/cfg_wdata_i; the user must
//    write them only while the block is idle, which the block does not enforce.
//  - A search scans the use area one unit a cycle through the single map
//    port; a next fit search that finds nothing from the resume index
//    restarts from index 0, and first and next fit stop early on a hit.
//    A query walks back to the run start and then forward, one unit a
//    cycle each way.
//  - One operation is worked on at a time. The result sits in an output
//    register, so a new operation is taken while it waits; if the receiver
//    stalls, the next result is held until the register frees.
//  - After reset a clearing pass marks every unit free; in_ready_o stays
//    low until it finishes.

module heap_fit_search_top import hfs_pkg::*; #(
  parameter int unsigned MAP_DEPTH = MAP_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CFG_A_W-1:0] cfg_index_i,
  input  logic [POS_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [CIDX_W-1:0]  entry_index_i,
  input  logic               entry_in_use_i,
  input  logic [POS_W-1:0]   request_size_i,
  input  logic [CIDX_W-1:0]  resume_index_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [CIDX_W-1:0]  chunk_index_o,
  output logic [POS_W-1:0]   chunk_size_o
);

  localparam int unsigned AW = $clog2(MAP_DEPTH);

  fit_e             strategy_q;
  logic [POS_W-1:0] active_q;
  cfg_t             cfg;
  map_ctl_t         map_ctl;
  logic [AW-1:0]    map_addr;
  logic             map_rdata;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             out_valid_q;
  res_t             out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strategy_q <= FIT_FIRST;
      active_q   <= AREA_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_STRATEGY) begin
        strategy_q <= fit_e'(cfg_wdata_i[1:0]);
      end else begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  // Use area is clipped to the map depth
  assign cfg.strategy = strategy_q;
  assign cfg.area     = (32'(active_q) > MAP_DEPTH) ? POS_W'(MAP_DEPTH) : active_q;

  hfs_map_ram #(
    .MAP_DEPTH (MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .ctl_i   (map_ctl),
    .addr_i  (map_addr),
    .rdata_o (map_rdata)
  );

  hfs_ctrl #(
    .MAP_DEPTH (MAP_DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .entry_index_i  (entry_index_i),
    .entry_in_use_i (entry_in_use_i),
    .request_size_i (request_size_i),
    .resume_index_i (resume_index_i),
    .map_ctl_o      (map_ctl),
    .map_addr_o     (map_addr),
    .map_rdata_i    (map_rdata),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // Output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_q.found;
  assign chunk_index_o = out_q.chunk_index;
  assign chunk_size_o  = out_q.chunk_size;

endmodule

>>> sv/hfs_map_ram.sv
// Use/free map storage: one bit per heap unit, one port, registered read.
// Depends on hfs_pkg for the write control struct.

module hfs_map_ram import hfs_pkg::*; #(
  parameter int unsigned MAP_DEPTH = MAP_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  map_ctl_t                     ctl_i,
  input  logic [$clog2(MAP_DEPTH)-1:0] addr_i,
  output logic                         rdata_o
);

  logic mem [MAP_DEPTH];
  logic rdata_q;

  // Write, and registered read for the next cycle; a read at a written address returns the old bit
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= ctl_i.wbit;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/hfs_ctrl.sv
// Sequencer for the heap fit search: clearing pass, map writes, run scans
// and run size queries over the map memory. Depends on hfs_pkg.

module hfs_ctrl import hfs_pkg::*; #(
  parameter int unsigned MAP_DEPTH = MAP_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  // input transactions
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   opcode_i,
  input  logic [CIDX_W-1:0]            entry_index_i,
  input  logic                         entry_in_use_i,
  input  logic [POS_W-1:0]             request_size_i,
  input  logic [CIDX_W-1:0]            resume_index_i,
  // map memory
  output map_ctl_t                     map_ctl_o,
  output logic [$clog2(MAP_DEPTH)-1:0] map_addr_o,
  input  logic                         map_rdata_i,
  // results
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output res_t                         res_o
);

  localparam int unsigned AW = $clog2(MAP_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_DEPTH - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_QBACK = 6'b001000,
    ST_QFWD  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [POS_W-1:0] rd_p_q, rd_p_d;     // next position to read
  logic             pv_q, pv_d;         // read data valid for pp_q
  logic [POS_W-1:0] pp_q, pp_d;         // position of the data in hand
  logic [POS_W-1:0] run_q, run_d;
  logic             have_q, have_d;
  logic             second_q, second_d; // scan from index 0 in progress
  logic [POS_W-1:0] best_len_q, best_len_d;
  logic [POS_W-1:0] best_at_q, best_at_d;
  logic [POS_W-1:0] want_q, want_d;
  res_t             res_q, res_d;

  logic [POS_W-1:0] addr_pos;
  logic [31:0]      addr_wide;
  op_e              op;
  logic             idx_ok;
  logic             p_lt_end;
  logic             is_free;
  logic [POS_W-1:0] run_inc;
  logic [POS_W-1:0] run_at;
  logic             extreme;
  logic             take;
  logic             upd;

  assign op       = op_e'(opcode_i);
  assign idx_ok   = 32'(entry_index_i) < MAP_DEPTH;
  assign p_lt_end = pp_q < cfg_i.area;
  assign is_free  = p_lt_end && !map_rdata_i;
  assign run_inc  = run_q + 11'd1;
  assign run_at   = pp_q - run_q;
  assign extreme  = (cfg_i.strategy == FIT_BEST) || (cfg_i.strategy == FIT_WORST);

  // Best/worst fit: closing run replaces the held one (earliest wins ties)
  always_comb begin
    if (cfg_i.strategy == FIT_WORST) begin
      take = !have_q || (run_q > best_len_q);
    end else begin
      take = !have_q || (run_q < best_len_q);
    end
    upd = pv_q && !is_free && (run_q >= want_q) && take;
  end

  // Next state and datapath
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    rd_p_d     = rd_p_q;
    pv_d       = pv_q;
    pp_d       = pp_q;
    run_d      = run_q;
    have_d     = have_q;
    second_d   = second_q;
    best_len_d = best_len_q;
    best_at_d  = best_at_q;
    want_d     = want_q;
    res_d      = res_q;
    addr_pos   = rd_p_q;
    map_ctl_o  = '0;
    in_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        map_ctl_o.we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready_o     = 1'b1;
        addr_pos       = POS_W'(entry_index_i);
        map_ctl_o.wbit = entry_in_use_i;
        map_ctl_o.we   = in_valid_i && (op == OP_WRITE) && idx_ok;
        pv_d  = 1'b0;
        run_d = '0;
        if (in_valid_i) begin
          unique case (op)
            OP_SEARCH: begin
              want_d = request_size_i;
              have_d = 1'b0;
              if (request_size_i == '0) begin
                res_d   = '0;
                state_d = ST_DONE;
              end else begin
                state_d = ST_SCAN;
                if ((cfg_i.strategy == FIT_NEXT) && (resume_index_i != '0)) begin
                  rd_p_d   = POS_W'(resume_index_i);
                  second_d = 1'b0;
                end else begin
                  rd_p_d   = '0;
                  second_d = 1'b1;
                end
              end
            end
            OP_QUERY: begin
              if (idx_ok) begin
                rd_p_d  = POS_W'(entry_index_i);
                state_d = ST_QBACK;
              end else begin
                res_d   = '0;
                state_d = ST_DONE;
              end
            end
            default: ;
          endcase
        end
      end

      // Forward scan, one unit a cycle; position area counts as used
      ST_SCAN: begin
        rd_p_d = rd_p_q + 11'd1;
        pv_d   = 1'b1;
        pp_d   = rd_p_q;
        if (pv_q) begin
          run_d = is_free ? run_inc : '0;
          if (extreme) begin
            if (upd) begin
              have_d     = 1'b1;
              best_len_d = run_q;
              best_at_d  = run_at;
            end
            if (!p_lt_end) begin
              res_d.found       = upd || have_q;
              res_d.chunk_index = upd ? run_at[CIDX_W-1:0]
                                      : (have_q ? best_at_q[CIDX_W-1:0] : '0);
              res_d.chunk_size  = '0;
              state_d = ST_DONE;
            end
          end else if (is_free && (run_inc == want_q)) begin
            res_d.found       = 1'b1;
            res_d.chunk_index = run_at[CIDX_W-1:0];
            res_d.chunk_size  = '0;
            state_d = ST_DONE;
          end else if (!p_lt_end) begin
            if (!second_q) begin
              // next fit found nothing from the resume point: start over
              rd_p_d   = '0;
              pv_d     = 1'b0;
              run_d    = '0;
              second_d = 1'b1;
            end else begin
              res_d   = '0;
              state_d = ST_DONE;
            end
          end
        end
      end

      // Walk back to the start of the free run around the queried unit
      ST_QBACK: begin
        rd_p_d = rd_p_q - 11'd1;
        pv_d   = 1'b1;
        pp_d   = rd_p_q;
        if (pv_q && (map_rdata_i || (pp_q == '0))) begin
          rd_p_d  = map_rdata_i ? (pp_q + 11'd1) : '0;
          pv_d    = 1'b0;
          run_d   = '0;
          state_d = ST_QFWD;
        end
      end

      // Count free units forward while inside the use area
      ST_QFWD: begin
        rd_p_d = rd_p_q + 11'd1;
        pv_d   = 1'b1;
        pp_d   = rd_p_q;
        if (pv_q) begin
          if (is_free) begin
            run_d = run_inc;
          end else begin
            res_d.found       = 1'b0;
            res_d.chunk_index = '0;
            res_d.chunk_size  = run_q;
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Memory address: clearing counter in the clearing pass, else entry index or read position
  assign addr_wide  = 32'(addr_pos);
  assign map_addr_o = (state_q == ST_CLEAR) ? clr_q : addr_wide[AW-1:0];

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      pv_q     <= 1'b0;
      have_q   <= 1'b0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      pv_q     <= pv_d;
      have_q   <= have_d;
      second_q <= second_d;
    end
  end

  // Payload and counters
  always_ff @(posedge clk_i) begin
    rd_p_q     <= rd_p_d;
    pp_q       <= pp_d;
    run_q      <= run_d;
    best_len_q <= best_len_d;
    best_at_q  <= best_at_d;
    want_q     <= want_d;
    res_q      <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> tb/sv/tb_heap_fit_search_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for heap_fit_search_top: directed table, then random phases.
// Depends on hfs_pkg and the heap_fit_search_top RTL; predicts results from its own map copy.

module tb_heap_fit_search_top;
  import hfs_pkg::*;

  localparam int MAP_UNITS      = MAP_DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 500;
  localparam int SETTLE_CYCLES  = 16;
  localparam int FINAL_CYCLES   = 2 * MAP_UNITS + 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PRINT_CAP      = 30;

  // opcode 3 is unused by the block and must be dropped
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef enum bit {ROW_OP, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [CFG_A_W-1:0] reg_idx;
    logic [POS_W-1:0]   reg_val;
    logic [1:0]         op;
    logic [CIDX_W-1:0]  idx;
    logic               mark;
    logic [POS_W-1:0]   want;
    logic [CIDX_W-1:0]  resume;
    bit                 typed;
    res_t               known;
  } row_t;

  // DUT connections
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_index = '0;
  logic [POS_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         opcode = '0;
  logic [CIDX_W-1:0]  entry_index = '0;
  logic               entry_in_use = 1'b0;
  logic [POS_W-1:0]   request_size = '0;
  logic [CIDX_W-1:0]  resume_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               found;
  logic [CIDX_W-1:0]  chunk_index;
  logic [POS_W-1:0]   chunk_size;

  // typed-in answer travelling with the transaction on the input channel
  bit   cur_typed = 1'b0;
  res_t cur_known = '0;

  // predictor state
  bit               unit_used [MAP_UNITS];
  fit_e             cur_strategy = FIT_FIRST;
  logic [POS_W-1:0] cur_area = AREA_RST;

  res_t awaited_res [$];
  row_t dir_rows [$];

  int  n_errors = 0;
  int  n_in = 0;
  int  n_results = 0;
  int  n_found = 0;
  int  n_settings = 0;
  int  idle_cycles = 0;
  bit  rx_steady = 1'b0;
  int  rx_left = 0;
  bit  rx_on = 1'b0;

  heap_fit_search_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .opcode_i       (opcode),
    .entry_index_i  (entry_index),
    .entry_in_use_i (entry_in_use),
    .request_size_i (request_size),
    .resume_index_i (resume_index),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .found_o        (found),
    .chunk_index_o  (chunk_index),
    .chunk_size_o   (chunk_size)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // use area clipped to the map
  function automatic int area_end();
    return (cur_area > MAP_UNITS) ? MAP_UNITS : int'(cur_area);
  endfunction

  // first run of exactly want free units, scanning up from start
  function automatic bit scan_free_from(input int start, input int want, output int at);
    int stop;
    int run;
    stop = area_end();
    run  = 0;
    at   = 0;
    for (int i = start; i < stop; i++) begin
      run = unit_used[i] ? 0 : run + 1;
      if (run == want) begin
        at = i + 1 - want;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // smallest (or largest) whole free run that fits; earliest wins ties
  function automatic bit scan_free_span(input int want, input bit largest, output int at);
    int stop;
    int run;
    int best_len;
    bit have;
    bit is_free;
    bit take;
    stop     = area_end();
    run      = 0;
    best_len = 0;
    have     = 1'b0;
    at       = 0;
    for (int i = 0; i <= stop; i++) begin
      is_free = (i < stop) && !unit_used[i];
      if (is_free) begin
        run++;
      end else begin
        if (run >= want) begin
          take = !have || (largest ? run > best_len : run < best_len);
          if (take) begin
            have     = 1'b1;
            best_len = run;
            at       = i - run;
          end
        end
        run = 0;
      end
    end
    return have;
  endfunction

  // free run around idx, or just after it when idx is in use
  function automatic int free_run_at(input int idx);
    int stop;
    int s;
    int n;
    stop = area_end();
    n    = 0;
    if (unit_used[idx]) begin
      s = idx + 1;
    end else begin
      s = idx;
      while (s > 0 && !unit_used[s-1]) s--;
    end
    while (s < stop && !unit_used[s]) begin
      n++;
      s++;
    end
    return n;
  endfunction

  // applies one transaction to the map copy; returns 1 when a result is due
  function automatic bit apply_heap_op(input logic [1:0] op, input logic [CIDX_W-1:0] idx,
                                       input logic mark, input logic [POS_W-1:0] want,
                                       input logic [CIDX_W-1:0] resume, output res_t r);
    int at;
    bit hit;
    r   = '0;
    at  = 0;
    hit = 1'b0;
    case (op)
      OP_WRITE: begin
        unit_used[idx] = mark;
        return 1'b0;
      end
      OP_QUERY: begin
        r.chunk_size = POS_W'(free_run_at(int'(idx)));
        return 1'b1;
      end
      OP_SEARCH: begin
        if (want != '0) begin
          case (cur_strategy)
            FIT_FIRST: hit = scan_free_from(0, int'(want), at);
            FIT_NEXT: begin
              if (resume != '0) hit = scan_free_from(int'(resume), int'(want), at);
              if (!hit) hit = scan_free_from(0, int'(want), at);
            end
            FIT_BEST: hit = scan_free_span(int'(want), 1'b0, at);
            default:  hit = scan_free_span(int'(want), 1'b1, at);
          endcase
        end
        r.found       = hit;
        r.chunk_index = hit ? CIDX_W'(at) : '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    if (n_errors < PRINT_CAP)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    n_errors++;
  endtask

  // result channel is compared before the input channel is predicted
  always @(posedge clk) begin
    res_t pred;
    res_t due;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (found) n_found++;
        if (awaited_res.size() == 0) begin
          report_mismatch("result transaction with nothing outstanding", 1, 0);
        end else begin
          due = awaited_res.pop_front();
          if (found !== due.found) report_mismatch("found", found, due.found);
          if (chunk_index !== due.chunk_index)
            report_mismatch("chunk_index", chunk_index, due.chunk_index);
          if (chunk_size !== due.chunk_size)
            report_mismatch("chunk_size", chunk_size, due.chunk_size);
        end
      end
      if (in_valid && in_ready) begin
        n_in++;
        if (apply_heap_op(opcode, entry_index, entry_in_use, request_size, resume_index, pred))
          awaited_res.push_back(cur_typed ? cur_known : pred);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("heap_fit_search_top regression: fail");
        $finish;
      end
    end
  end

  // receiver: alternating ready and stall stretches of random length, or steady ready when rx_steady is set
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_on   = !rx_on;
      rx_left = rx_on ? $urandom_range(1, 24) : $urandom_range(1, 10);
    end else begin
      rx_left--;
    end
    out_ready <= rx_steady || rx_on;
  end

  // ---------------------------------------------------------------- driving

  task automatic drive_item(input logic [1:0] op, input logic [CIDX_W-1:0] idx,
                            input logic mark, input logic [POS_W-1:0] want,
                            input logic [CIDX_W-1:0] resume, input bit typed,
                            input res_t known);
    @(negedge clk);
    in_valid     <= 1'b1;
    opcode       <= op;
    entry_index  <= idx;
    entry_in_use <= mark;
    request_size <= want;
    resume_index <= resume;
    cur_typed    <= typed;
    cur_known    <= known;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait for every outstanding result, then let the block settle
  task automatic drain_results(input int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_res.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] ridx, input logic [POS_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ridx;
    cfg_wdata <= val;
    if (ridx == CFG_STRATEGY) cur_strategy = fit_e'(val[1:0]);
    else cur_area = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic res_t res_of(input bit f, input int cidx, input int csize);
    res_t r;
    r.found       = f;
    r.chunk_index = CIDX_W'(cidx);
    r.chunk_size  = POS_W'(csize);
    return r;
  endfunction

  function automatic void add_op(input logic [1:0] op, input int idx, input bit mark,
                                 input int want, input int resume, input bit typed = 1'b0,
                                 input res_t known = '0);
    row_t r;
    r.kind    = ROW_OP;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.op      = op;
    r.idx     = CIDX_W'(idx);
    r.mark    = mark;
    r.want    = POS_W'(want);
    r.resume  = CIDX_W'(resume);
    r.typed   = typed;
    r.known   = known;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_reg(input logic [CFG_A_W-1:0] ridx, input int val);
    row_t r;
    r.kind    = ROW_REG;
    r.reg_idx = ridx;
    r.reg_val = POS_W'(val);
    r.op      = OP_SPARE;
    r.idx     = '0;
    r.mark    = 1'b0;
    r.want    = '0;
    r.resume  = '0;
    r.typed   = 1'b0;
    r.known   = '0;
    dir_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------- sequence

  initial begin
    row_t             row;
    res_t             nothing;
    logic [1:0]       op;
    logic [CIDX_W-1:0] idx;
    logic [CIDX_W-1:0] resume;
    logic [POS_W-1:0] want;
    logic [POS_W-1:0] area;
    int               ae;
    int               lim;
    int               pick;
    int               phase_len;
    int               burst_left;
    int               n_random;
    int               n_big;
    int               n_dir;
    bit               tx_steady;

    nothing    = '0;
    n_random   = 0;
    n_big      = 0;
    burst_left = 0;
    tx_steady  = 1'b0;
    foreach (unit_used[k]) unit_used[k] = 1'b0;

    // directed table; first rows run on the reset configuration
    add_op(OP_QUERY,  1023, 0, 1,    0,    1'b1, res_of(0, 0, 1024));
    add_op(OP_SEARCH, 0,    0, 1024, 0,    1'b1, res_of(1, 0, 0));
    add_op(OP_SEARCH, 0,    0, 0,    0,    1'b1, nothing);          // zero request
    add_op(OP_SEARCH, 0,    0, 1025, 0,    1'b1, nothing);          // larger than the area
    add_op(OP_SEARCH, 1023, 1, 2047, 1023, 1'b1, nothing);
    add_op(OP_WRITE,  0,    1, 0,    0);
    add_op(OP_WRITE,  1023, 1, 0,    0);
    add_op(OP_QUERY,  0,    0, 0,    0);                            // used unit
    add_op(OP_SPARE,  1023, 1, 2047, 1023);                         // dropped opcode
    add_op(OP_QUERY,  1023, 0, 0,    0);                            // used, next is outside
    add_op(OP_WRITE,  512,  1, 0,    0);
    add_op(OP_SEARCH, 0,    0, 1022, 0);
    add_reg(CFG_AREA, 2047);                                        // oversized area
    add_op(OP_SEARCH, 0,    0, 511,  0);
    add_reg(CFG_STRATEGY, FIT_BEST);
    add_op(OP_SEARCH, 0,    0, 100,  0);
    add_reg(CFG_STRATEGY, FIT_WORST);
    add_op(OP_SEARCH, 0,    0, 100,  0);
    add_reg(CFG_STRATEGY, FIT_NEXT);
    add_op(OP_SEARCH, 0,    0, 4,    1000);
    add_op(OP_SEARCH, 0,    0, 100,  1000);                         // retry from index 0
    add_reg(CFG_AREA, 16);
    add_op(OP_SEARCH, 0,    0, 4,    600);                          // resume outside the area
    add_op(OP_QUERY,  700,  0, 0,    0);
    add_op(OP_QUERY,  200,  0, 0,    0);                            // run reaches back in
    add_reg(CFG_AREA, 0);
    add_op(OP_SEARCH, 0,    0, 1,    0,    1'b1, nothing);          // empty area
    add_op(OP_QUERY,  5,    0, 0,    0,    1'b1, nothing);
    add_reg(CFG_AREA, 1);
    add_op(OP_SEARCH, 0,    0, 1,    0,    1'b1, nothing);
    add_op(OP_WRITE,  0,    0, 0,    0);
    add_op(OP_SEARCH, 0,    0, 1,    0);

    // reset, then wait out the clearing pass
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!in_ready);

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      if (row.kind == ROW_REG) begin
        drain_results(SETTLE_CYCLES);
        write_reg(row.reg_idx, row.reg_val);
        n_settings++;
      end else begin
        drive_item(row.op, row.idx, row.mark, row.want, row.resume, row.typed, row.known);
      end
    end
    n_dir = n_in;

    // random phases, each with its own register setting and traffic shape
    while (n_random < RANDOM_ITEMS) begin
      drain_results(SETTLE_CYCLES);
      pick = $urandom_range(0, 15);
      if (pick == 0) area = 0;
      else if (pick == 1) area = 1;
      else if (pick == 2 && n_big < 3) area = 1024;
      else if (pick == 3 && n_big < 3) area = POS_W'($urandom_range(1025, 2047));
      else area = POS_W'($urandom_range(2, 64));
      if (area >= 1024) n_big++;
      write_reg(CFG_STRATEGY, POS_W'($urandom_range(0, 3)));
      write_reg(CFG_AREA, area);
      n_settings++;
      ae        = (area > MAP_UNITS) ? MAP_UNITS : int'(area);
      lim       = (ae < 1) ? 1 : ae;
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(25, 60);

      for (int j = 0; j < phase_len && n_random < RANDOM_ITEMS; j++) begin
        // sender bursts with gaps in between
        if (!tx_steady && burst_left == 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat ($urandom_range(0, 10)) @(negedge clk);
          burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;

        pick = $urandom_range(0, 19);
        if (pick <= 8) op = OP_WRITE;
        else if (pick <= 14) op = OP_SEARCH;
        else if (pick <= 18) op = OP_QUERY;
        else op = OP_SPARE;

        // indices mostly near the use area, now and then anywhere in the map
        if ($urandom_range(0, 9) < 8)
          idx = CIDX_W'($urandom_range(0, (ae + 3 > 1023) ? 1023 : ae + 3));
        else idx = CIDX_W'($urandom_range(0, 1023));

        pick = $urandom_range(0, 9);
        if (pick <= 5) want = POS_W'($urandom_range(1, (lim < 8) ? lim : 8));
        else if (pick <= 7) want = POS_W'($urandom_range(1, lim + 1));
        else if (pick == 8) want = POS_W'($urandom_range(0, 2047));
        else want = $urandom_range(0, 1) ? POS_W'(0) : POS_W'(1024);

        if ($urandom_range(0, 9) < 7) resume = CIDX_W'($urandom_range(0, (ae > 1023) ? 1023 : ae));
        else resume = CIDX_W'($urandom_range(0, 1023));

        drive_item(op, idx, 1'($urandom_range(0, 1)), want, resume, 1'b0, nothing);
        if (op != OP_SPARE) n_random++;

        // now and then hold off until everything outstanding is back
        if ($urandom_range(0, 79) == 0) drain_results(0);
      end
    end

    drain_results(FINAL_CYCLES);

    $display("covered %0d transactions in (%0d from the directed table), %0d results checked",
             n_in, n_dir, n_results);
    $display("%0d searches found a run; %0d register settings; %0d mismatches",
             n_found, n_settings, n_errors);
    if (n_errors == 0) begin
      $display("heap_fit_search_top regression: pass");
    end else begin
      $display("heap_fit_search_top regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/hfs_pkg.sv
sv/hfs_map_ram.sv
sv/hfs_ctrl.sv
sv/heap_fit_search_top.sv
tb/sv/tb_heap_fit_search_top.sv
